FILE: rtl/timeslice_task_scheduler_defines.svh
// Assertion macros for the scheduler RTL
`ifndef TIMESLICE_TASK_SCHEDULER_DEFINES_SVH
`define TIMESLICE_TASK_SCHEDULER_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define TTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/tts_pkg.sv
// Package: constants and codes for the timeslice task scheduler
package tts_pkg;
   localparam int NumSlots = 16;
   localparam int SlotW = $clog2(NumSlots);
   localparam int CntW = $clog2(NumSlots + 1);
   localparam logic [9:0] MsPerSecond = 10'd1000;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_SLEEPING = 2'd2;
   localparam logic [1:0] ST_EXITED = 2'd3;

   localparam logic [2:0] REQ_TICK = 3'd0;
   localparam logic [2:0] REQ_SLEEP = 3'd1;
   localparam logic [2:0] REQ_YIELD = 3'd2;
   localparam logic [2:0] REQ_SPAWN = 3'd3;
   localparam logic [2:0] REQ_FINISH = 3'd4;
   localparam logic [2:0] REQ_RELEASE = 3'd5;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  task_id;
      logic [15:0] sleep_seconds;
      logic [15:0] random_draw;
   } req_type_type;

   typedef struct packed {
      logic       switched;
      logic [3:0] next_task;
      logic       none_ready;
   } rsp_type;
endpackage

FILE: rtl/tts_req_if.sv
// Valid/ready channel interfaces for requests and responses
interface tts_req_if;
   logic valid;
   logic ready;
   tts_pkg::req_type_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tts_rsp_if;
   logic valid;
   logic ready;
   tts_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/timeslice_task_scheduler.sv
// Top level: timeslice lottery task scheduler over a table of task slots
// One request transaction is accepted at a time. After acceptance, a request
// that leads to a pick passes through the apply state, a wake sweep, a count
// sweep, a bit-serial modulo, the select sweep and the output state, each sweep
// stepping one slot per cycle through a shared compare/count unit. When no
// slot has slice left, a refill sweep and a second count sweep are added.
// Spawn, release and non-picking requests go from the apply state straight to
// the output state. The response register holds the input off until the
// response is taken, and the input is ready again the cycle after that.
// slice_reload may be written while idle.
`include "timeslice_task_scheduler_defines.svh"
module timeslice_task_scheduler (
   input  logic       clock,
   input  logic       reset,
   tts_req_if.sink    req,
   tts_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);
   localparam int N = tts_pkg::NumSlots;
   localparam int SW = tts_pkg::SlotW;
   localparam int CW = tts_pkg::CntW;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_WAKE = 3'd2;
   localparam logic [2:0] S_COUNT = 3'd3;
   localparam logic [2:0] S_REFILL = 3'd4;
   localparam logic [2:0] S_MOD = 3'd5;
   localparam logic [2:0] S_SELECT = 3'd6;
   localparam logic [2:0] S_OUT = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [7:0]  reload_ff;
   logic [1:0]  status_ff [N];
   logic [7:0]  slice_ff [N];
   logic [31:0] wake_ff [N];
   logic [31:0] now_ff;
   logic [SW-1:0] run_ff;
   logic        runv_ff;
   tts_pkg::req_type_type cmd_ff;
   logic [SW-1:0] idx_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] target_ff;
   logic        refilled_ff;
   logic        rspv_ff;
   tts_pkg::rsp_type rsp_ff;
   logic [31:0] sleep_ms;
   logic        div_start, div_done;
   logic [CW-1:0] div_rem;
   logic        tid_ok;
   logic [SW-1:0] tid;
   logic        elig;
   logic        last;

   assign tid = cmd_ff.task_id[SW-1:0];
   assign tid_ok = ({28'd0, cmd_ff.task_id} < 32'(N));
   assign elig = (status_ff[idx_ff] == tts_pkg::ST_RUNNABLE) && (slice_ff[idx_ff] != 8'd0);
   assign last = (idx_ff == SW'(N - 1));
   assign sleep_ms = 32'(cmd_ff.sleep_seconds) * 32'(tts_pkg::MsPerSecond);
   assign div_start = (state_ff == S_COUNT) && last && !((cnt_ff + CW'(elig)) == '0);

   tts_divmod u_divmod (
      .clock(clock), .reset(reset), .start(div_start), .dividend(cmd_ff.random_draw),
      .divisor(cnt_ff + CW'(elig)), .done(div_done), .remainder(div_rem)
   );

   assign req.ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp.valid = rspv_ff;
   assign rsp.data = rsp_ff;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_EXEC;
         // a pick follows unless the request settles in the apply cycle
         S_EXEC: begin
            state_in = S_OUT;
            case (cmd_ff.req_type) inside
               tts_pkg::REQ_TICK:
                  if (!(runv_ff && status_ff[run_ff] == tts_pkg::ST_RUNNABLE &&
                        slice_ff[run_ff] > 8'd1))
                     state_in = S_WAKE;
               tts_pkg::REQ_SLEEP, tts_pkg::REQ_YIELD: state_in = S_WAKE;
               tts_pkg::REQ_FINISH:
                  if (tid_ok && status_ff[tid] != tts_pkg::ST_EMPTY &&
                      runv_ff && run_ff == tid)
                     state_in = S_WAKE;
               default: ;
            endcase
         end
         S_WAKE: if (last) state_in = S_COUNT;
         S_COUNT: if (last) begin
            if ((cnt_ff + CW'(elig)) != '0) state_in = S_MOD;
            else if (!refilled_ff) state_in = S_REFILL;
            else state_in = S_OUT;
         end
         S_REFILL: if (last) state_in = S_COUNT;
         S_MOD: if (div_done) state_in = S_SELECT;
         S_SELECT: if (elig && cnt_ff == target_ff) state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         reload_ff <= 8'd10;
         now_ff <= '0;
         run_ff <= '0;
         runv_ff <= 1'b0;
         rspv_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            status_ff[i] <= tts_pkg::ST_EMPTY;
            slice_ff[i] <= '0;
            wake_ff[i] <= '0;
         end
      end else begin
         if (csr_we) reload_ff <= csr_wdata;
         if (rsp.valid && rsp.ready) rspv_ff <= 1'b0;
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               cmd_ff <= req.data;
               rsp_ff <= '0;
            end
            // apply the request
            S_EXEC: begin
               idx_ff <= '0;
               cnt_ff <= '0;
               refilled_ff <= 1'b0;
               case (cmd_ff.req_type) inside
                  tts_pkg::REQ_TICK: begin
                     now_ff <= now_ff + 32'd1;
                     if (runv_ff && status_ff[run_ff] == tts_pkg::ST_RUNNABLE) begin
                        if (slice_ff[run_ff] > 8'd1)
                           slice_ff[run_ff] <= slice_ff[run_ff] - 8'd1;
                        else slice_ff[run_ff] <= 8'd0;
                     end
                  end
                  tts_pkg::REQ_SLEEP, tts_pkg::REQ_YIELD: begin
                     if (runv_ff && (status_ff[run_ff] == tts_pkg::ST_RUNNABLE ||
                                     status_ff[run_ff] == tts_pkg::ST_SLEEPING)) begin
                        slice_ff[run_ff] <= reload_ff;
                        if (cmd_ff.req_type == tts_pkg::REQ_SLEEP) begin
                           status_ff[run_ff] <= tts_pkg::ST_SLEEPING;
                           wake_ff[run_ff] <= now_ff + sleep_ms;
                        end else status_ff[run_ff] <= tts_pkg::ST_RUNNABLE;
                     end
                  end
                  tts_pkg::REQ_SPAWN:
                     if (tid_ok && status_ff[tid] == tts_pkg::ST_EMPTY) begin
                        status_ff[tid] <= tts_pkg::ST_RUNNABLE;
                        slice_ff[tid] <= reload_ff;
                        wake_ff[tid] <= '0;
                     end
                  tts_pkg::REQ_FINISH:
                     if (tid_ok && status_ff[tid] != tts_pkg::ST_EMPTY)
                        status_ff[tid] <= tts_pkg::ST_EXITED;
                  tts_pkg::REQ_RELEASE:
                     if (tid_ok && status_ff[tid] == tts_pkg::ST_EXITED) begin
                        status_ff[tid] <= tts_pkg::ST_EMPTY;
                        slice_ff[tid] <= '0;
                        wake_ff[tid] <= '0;
                     end
                  default: ;
               endcase
            end
            // wake sleepers whose time has passed
            S_WAKE: begin
               if (status_ff[idx_ff] == tts_pkg::ST_SLEEPING && now_ff > wake_ff[idx_ff]) begin
                  status_ff[idx_ff] <= tts_pkg::ST_RUNNABLE;
                  slice_ff[idx_ff] <= reload_ff;
               end
               idx_ff <= last ? '0 : idx_ff + SW'(1);
            end
            // count eligible slots
            S_COUNT: begin
               cnt_ff <= cnt_ff + CW'(elig);
               idx_ff <= last ? '0 : idx_ff + SW'(1);
               if (last && (cnt_ff + CW'(elig)) == '0 && refilled_ff) begin
                  runv_ff <= 1'b0;
                  rsp_ff.none_ready <= 1'b1;
               end
            end
            // refill every live slot
            S_REFILL: begin
               refilled_ff <= 1'b1;
               cnt_ff <= '0;
               if (status_ff[idx_ff] == tts_pkg::ST_RUNNABLE ||
                   status_ff[idx_ff] == tts_pkg::ST_SLEEPING)
                  slice_ff[idx_ff] <= reload_ff;
               idx_ff <= last ? '0 : idx_ff + SW'(1);
            end
            S_MOD: begin
               cnt_ff <= '0;
               if (div_done) target_ff <= div_rem;
            end
            // walk eligible slots to the target rank
            S_SELECT: begin
               if (elig) begin
                  cnt_ff <= cnt_ff + CW'(1);
                  if (cnt_ff == target_ff) begin
                     run_ff <= idx_ff;
                     runv_ff <= 1'b1;
                     rsp_ff.switched <= 1'b1;
                     rsp_ff.next_task <= 4'(idx_ff);
                  end
               end
               idx_ff <= idx_ff + SW'(1);
            end
            S_OUT: rspv_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   `TTS_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req.ready)
   `TTS_ASSERT_IMP(a_rsp_flags, clock, reset, rsp.valid, !(rsp.data.switched && rsp.data.none_ready))
   `TTS_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT, rsp.valid)
   `TTS_ASSERT_IMP(a_switch_run, clock, reset, rsp.valid && rsp.data.switched, runv_ff)
endmodule

FILE: rtl/tts_divmod.sv
// Restoring remainder unit: draw mod count, one quotient bit per cycle
module tts_divmod (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [15:0]              dividend,
   input  logic [tts_pkg::CntW-1:0] divisor,
   output logic                     done,
   output logic [tts_pkg::CntW-1:0] remainder
);
   logic [15:0]              quo_ff, quo_in;
   logic [tts_pkg::CntW:0]   rem_ff, rem_in;
   logic [tts_pkg::CntW-1:0] dvs_ff, dvs_in;
   logic [4:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic [tts_pkg::CntW:0]   trial;

   assign trial = {rem_ff[tts_pkg::CntW-1:0], quo_ff[15]};

   // one shift-subtract step per cycle; divisor held from start
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[14:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) rem_in = trial - {1'b0, dvs_ff};
         else rem_in = trial;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd1);
   assign remainder = rem_in[tts_pkg::CntW-1:0];
endmodule
